// ----- hdl/tpss_pkg.sv -----
`default_nettype none
package tpss_pkg;

  // width of the packed x/y word before it is fitted to the frame
  localparam int unsigned PackedBits = 20;
  localparam int unsigned SampleBits = 10;

  // sender phase codes
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_CAPTURE  = 2'd1,
    PH_TRANSMIT = 2'd2
  } phase_t;

  // one result item
  typedef struct packed {
    phase_t phase;
    logic   data_line;
  } result_t;

endpackage
`default_nettype wire

// ----- hdl/touch_position_serial_sender.sv -----
`default_nettype none
// Touch position serial sender. Each input request is one wake event (host clock
// level plus X and Y samples); each one yields exactly one result request with
// the data pin level and the phase after that event. One request is taken every
// clock cycle while the output register can take it, and its result is valid
// in the cycle after acceptance; this follows from the single state update per
// event, which feeds one output register. Input is taken while that register is
// empty or being drained, so a stalled output holds the block. FRAME_BITS sets
// the frame length sent MSB first, followed by an XOR parity bit.
module touch_position_serial_sender #(
  parameter int unsigned FRAME_BITS = 20
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [0] clock_level, [10:1] x_sample, [20:11] y_sample, [23:21] zero
  input  wire logic [23:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] data_line, [2:1] phase, [7:3] zero
  output logic [7:0]       m_axis_tdata
);
  import tpss_pkg::*;

  localparam int unsigned CntBits = $clog2(FRAME_BITS + 1);

  phase_t                phase_reg, phase_next;
  logic [FRAME_BITS-1:0] frame_shift, frame_shift_next;
  logic [CntBits-1:0]    bits_sent, bits_sent_next;
  logic                  parity_bit, parity_bit_next;
  logic                  clock_tracker, clock_tracker_next;
  logic                  prev_nonzero, prev_nonzero_next;
  logic                  data_reg, data_next;
  logic                  accept;
  result_t               result;
  result_t               out_result;

  assign accept = s_axis_tvalid && s_axis_tready;

  // event logic
  tpss_step #(
    .FRAME_BITS(FRAME_BITS),
    .CNT_BITS  (CntBits)
  ) u_step (
    .clock_level       (s_axis_tdata[0]),
    .x_sample          (s_axis_tdata[10:1]),
    .y_sample          (s_axis_tdata[20:11]),
    .phase_reg         (phase_reg),
    .frame_shift       (frame_shift),
    .bits_sent         (bits_sent),
    .parity_bit        (parity_bit),
    .clock_tracker     (clock_tracker),
    .prev_nonzero      (prev_nonzero),
    .data_reg          (data_reg),
    .phase_next        (phase_next),
    .frame_shift_next  (frame_shift_next),
    .bits_sent_next    (bits_sent_next),
    .parity_bit_next   (parity_bit_next),
    .clock_tracker_next(clock_tracker_next),
    .prev_nonzero_next (prev_nonzero_next),
    .data_next         (data_next)
  );

  // sender state, updated once per accepted event
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg     <= PH_IDLE;
      frame_shift   <= '0;
      bits_sent     <= '0;
      parity_bit    <= 1'b0;
      clock_tracker <= 1'b0;
      prev_nonzero  <= 1'b0;
      data_reg      <= 1'b0;
    end else if (accept) begin
      phase_reg     <= phase_next;
      frame_shift   <= frame_shift_next;
      bits_sent     <= bits_sent_next;
      parity_bit    <= parity_bit_next;
      clock_tracker <= clock_tracker_next;
      prev_nonzero  <= prev_nonzero_next;
      data_reg      <= data_next;
    end
  end

  assign result.data_line = data_next;
  assign result.phase     = phase_next;

  // result register
  tpss_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (s_axis_tvalid),
    .result    (result),
    .load_ready(s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_result(out_result)
  );

  assign m_axis_tdata = {5'b0, out_result.phase, out_result.data_line};

  // every accepted event leaves a result waiting
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_axis_tvalid)
    else $error("accepted event produced no result");

  // the bit counter never passes the frame length
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    bits_sent <= CntBits'(FRAME_BITS))
    else $error("bit counter beyond frame length");

  // an idle event clears the bit counter and parity
  a_idle_clears: assert property (@(posedge clk) disable iff (rst)
    accept && phase_reg != PH_CAPTURE && phase_reg != PH_TRANSMIT
    |=> bits_sent == '0 && parity_bit == 1'b0 && clock_tracker)
    else $error("idle event did not clear transmit state");

  // entering transmit raises the data line in the result
  a_start_high: assert property (@(posedge clk) disable iff (rst)
    accept && phase_reg == PH_CAPTURE && phase_next == PH_TRANSMIT
    |=> m_axis_tdata[0] && m_axis_tdata[2:1] == PH_TRANSMIT)
    else $error("transmit start without data line high");

endmodule
`default_nettype wire

// ----- hdl/tpss_step.sv -----
`default_nettype none
module tpss_step #(
  parameter int unsigned FRAME_BITS = 20,
  parameter int unsigned CNT_BITS   = $clog2(FRAME_BITS + 1)
) (
  input  wire logic                     clock_level,
  input  wire logic [9:0]               x_sample,
  input  wire logic [9:0]               y_sample,
  input  wire tpss_pkg::phase_t         phase_reg,
  input  wire logic [FRAME_BITS-1:0]    frame_shift,
  input  wire logic [CNT_BITS-1:0]      bits_sent,
  input  wire logic                     parity_bit,
  input  wire logic                     clock_tracker,
  input  wire logic                     prev_nonzero,
  input  wire logic                     data_reg,
  output tpss_pkg::phase_t              phase_next,
  output logic [FRAME_BITS-1:0]         frame_shift_next,
  output logic [CNT_BITS-1:0]           bits_sent_next,
  output logic                          parity_bit_next,
  output logic                          clock_tracker_next,
  output logic                          prev_nonzero_next,
  output logic                          data_next
);
  import tpss_pkg::*;

  logic [PackedBits-1:0]            packed_xy;
  logic [PackedBits+FRAME_BITS-1:0] packed_wide;
  logic [FRAME_BITS-1:0]            frame;
  logic                             frame_nz;
  logic                             top_bit;

  // fit x:y to the frame, zero padded below or lowest bits dropped
  assign packed_xy   = {x_sample, y_sample};
  assign packed_wide = {packed_xy, FRAME_BITS'(0)};
  assign frame       = packed_wide[PackedBits+FRAME_BITS-1 -: FRAME_BITS];
  assign frame_nz    = |frame;
  assign top_bit     = frame_shift[FRAME_BITS-1];

  // next state for one event
  always_comb begin
    phase_next         = phase_reg;
    frame_shift_next   = frame_shift;
    bits_sent_next     = bits_sent;
    parity_bit_next    = parity_bit;
    clock_tracker_next = clock_tracker;
    prev_nonzero_next  = prev_nonzero;
    data_next          = data_reg;
    unique case (phase_reg)
      PH_CAPTURE: begin
        if (!clock_level) begin
          phase_next = PH_IDLE;
        end else begin
          frame_shift_next = frame;
          data_next        = 1'b0;
          if (prev_nonzero || frame_nz) begin
            prev_nonzero_next = frame_nz;
            data_next         = 1'b1;
            phase_next        = PH_TRANSMIT;
          end
        end
      end
      PH_TRANSMIT: begin
        if (clock_level == clock_tracker) begin
          // clock did not toggle: time out
          phase_next = PH_IDLE;
        end else begin
          clock_tracker_next = ~clock_tracker;
          if (bits_sent >= CNT_BITS'(FRAME_BITS)) begin
            data_next  = parity_bit;
            phase_next = PH_IDLE;
          end else begin
            data_next        = top_bit;
            parity_bit_next  = parity_bit ^ top_bit;
            frame_shift_next = {frame_shift[FRAME_BITS-2:0], 1'b0};
            bits_sent_next   = bits_sent + CNT_BITS'(1);
          end
        end
      end
      default: begin
        // idle, and the unused code treated as idle
        data_next          = 1'b0;
        bits_sent_next     = '0;
        parity_bit_next    = 1'b0;
        clock_tracker_next = 1'b1;
        phase_next         = clock_level ? PH_CAPTURE : PH_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/tpss_out_reg.sv -----
`default_nettype none
module tpss_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire tpss_pkg::result_t result,
  output logic                   load_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tpss_pkg::result_t      out_result
);
  import tpss_pkg::*;

  // takes a new result whenever the held one is gone or leaves this cycle
  assign load_ready = !out_valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ready) begin
      out_valid <= load;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load && load_ready) begin
      out_result <= result;
    end
  end

endmodule
`default_nettype wire
